/* rtl/modular_exponentiation_defines.svh */
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset.
`define MX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MX_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MX_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/modexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  localparam int EXP_BITS_DEF = 32;
  localparam int MOD_BITS_DEF = 31;

  localparam int BASE_W = 32;                 // base_value width
  localparam int RES_W  = 31;                 // residue width
  localparam int DATA_W = 32;                 // config data width
  localparam int ADDR_W = 3;                  // config byte address width
  localparam int CNT_W  = $clog2(BASE_W + 1); // multiplier bit counter

  localparam logic [RES_W-1:0] MOD_RESET = 31'd1000000007;

  // Register index (byte address bit 2)
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic {
    OP_MULT,
    OP_SQUARE
  } mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MULT,
    S_SQUARE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;      // capture operands, begin base reduction
    logic    start;     // begin a modular multiply
    mul_op_t op;
    logic    step;      // one multiplier bit
    logic    wb_res;    // write multiply result to res
    logic    wb_sq;     // write multiply result to sq
    logic    shift_exp; // consume one exponent bit
    logic    out_load;  // move res into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_zero;
    logic exp_bit;
    logic mod_zero;
    logic out_valid;
  } dp_sts_t;

endpackage

/* rtl/modexp_ctrl.sv */
// Sequencer for square-and-multiply: steps the shared modular multiplier.
`include "modular_exponentiation_defines.svh"

module modexp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  modexp_pkg::dp_sts_t sts,
  output modexp_pkg::dp_cmd_t cmd
);
  import modexp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_SQUARE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.mod_zero ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.step = 1'b1;
        if (sts.mul_last) begin
          cmd.wb_sq  = 1'b1;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (sts.exp_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.start = 1'b1;
          if (sts.exp_bit) begin
            cmd.op     = OP_MULT;
            state_next = S_MULT;
          end else begin
            state_next = S_SQUARE;
          end
        end
      end
      S_MULT: begin
        cmd.step = 1'b1;
        if (sts.mul_last) begin
          // result goes to res while the squaring starts from sq
          cmd.wb_res = 1'b1;
          cmd.start  = 1'b1;
          cmd.op     = OP_SQUARE;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.step = 1'b1;
        if (sts.mul_last) begin
          cmd.wb_sq     = 1'b1;
          cmd.shift_exp = 1'b1;
          state_next    = S_BIT;
        end
      end
      S_FINISH: begin
        if (!sts.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MX_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted while busy")
  `MX_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !sts.out_valid || out_ready, "result overwritten")
  `MX_ASSERT_IMP(a_shift_nonzero, clk, rst, cmd.shift_exp, !sts.exp_zero, "shift of empty exponent")

endmodule

/* rtl/modexp_datapath.sv */
// Operand registers, bit-serial modular multiplier and output register.
`include "modular_exponentiation_defines.svh"

module modexp_datapath #(
  parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
  parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  modexp_pkg::dp_cmd_t            cmd,
  output modexp_pkg::dp_sts_t            sts,
  input  logic [MOD_BITS-1:0]            modulus,
  input  logic [modexp_pkg::BASE_W-1:0]  base_value,
  input  logic [31:0]                    exponent,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [modexp_pkg::RES_W-1:0]   residue
);
  import modexp_pkg::*;

  localparam int SW = MOD_BITS + 2;

  logic [MOD_BITS-1:0] mod_q;
  logic [MOD_BITS-1:0] res;
  logic [MOD_BITS-1:0] sq;
  logic [EXP_BITS-1:0] e;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] mul_a;
  logic [BASE_W-1:0]   mb;
  logic [CNT_W-1:0]    cnt;

  logic [MOD_BITS-1:0] one_m;
  logic [MOD_BITS-1:0] acc_next;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       m1;
  logic [SW-1:0]       m2;
  logic [SW-1:0]       d1;
  logic [SW-1:0]       d2;

  assign one_m = (modulus > MOD_BITS'(1)) ? MOD_BITS'(1) : '0;

  // acc = (2*acc + bit*a) mod m; sum stays below 3m
  assign sum = {1'b0, acc, 1'b0} + {2'b00, (mb[BASE_W-1] ? mul_a : '0)};
  assign m1  = {2'b00, mod_q};
  assign m2  = {1'b0, mod_q, 1'b0};
  assign d1  = sum - m1;
  assign d2  = sum - m2;

  always_comb begin
    if (sum >= m2) begin
      acc_next = d2[MOD_BITS-1:0];
    end else if (sum >= m1) begin
      acc_next = d1[MOD_BITS-1:0];
    end else begin
      acc_next = sum[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_q <= modulus;
      res   <= one_m;
      e     <= EXP_BITS'(exponent);
      // base mod m: shift base bits in against a = 1
      mul_a <= one_m;
      mb    <= base_value;
      acc   <= '0;
      cnt   <= CNT_W'(BASE_W);
    end else if (cmd.start) begin
      mul_a <= (cmd.op == OP_MULT) ? res : sq;
      mb    <= {sq, {(BASE_W - MOD_BITS){1'b0}}};
      acc   <= '0;
      cnt   <= CNT_W'(MOD_BITS);
    end else if (cmd.step) begin
      acc <= acc_next;
      mb  <= mb << 1;
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.wb_res) begin
      res <= acc_next;
    end
    if (cmd.wb_sq) begin
      sq <= acc_next;
    end
    if (cmd.shift_exp) begin
      e <= e >> 1;
    end
    if (cmd.out_load) begin
      residue <= RES_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.mul_last  = (cnt == CNT_W'(1));
  assign sts.exp_zero  = (e == '0);
  assign sts.exp_bit   = e[0];
  assign sts.mod_zero  = (modulus == '0);
  assign sts.out_valid = out_valid;

  `MX_ASSERT_NXT(a_acc_below_mod, clk, rst, cmd.step, acc < mod_q, "partial product not reduced")
  `MX_ASSERT_IMP(a_valid_from_load, clk, rst, $rose(out_valid), $past(cmd.out_load), "result without load")

endmodule

/* rtl/modular_exponentiation.sv */
// Operation: the base is first reduced mod m bit by bit, then each exponent bit up to the highest
//   set one takes a squaring, preceded by a multiply into the result when the bit is set.
// One transaction at a time; the shift-add modular multiplier, one multiplier bit per cycle,
//   sets the rate. Next input is taken while a finished result waits at the output.
// Synchronous reset returns the sequencer to idle, empties the output and sets the
//   modulus to 1000000007.
module modular_exponentiation #(
  parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
  parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [modexp_pkg::ADDR_W-1:0]  paddr,
  input  logic [modexp_pkg::DATA_W-1:0]  pwdata,
  output logic [modexp_pkg::DATA_W-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [modexp_pkg::BASE_W-1:0]  base_value,
  input  logic [31:0]                    exponent,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [modexp_pkg::RES_W-1:0]   residue
);
  import modexp_pkg::*;

  logic [MOD_BITS-1:0] modulus;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(MOD_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS)) begin
      modulus <= pwdata[MOD_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MODULUS) ? DATA_W'(modulus) : '0;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  modexp_datapath #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .modulus    (modulus),
    .base_value (base_value),
    .exponent   (exponent),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .residue    (residue)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench for modular_exponentiation: directed and random power-mod transactions, scoreboarded.
module testbench;
  import modexp_pkg::*;

  localparam int MAX_CYCLES  = 4_000_000;
  localparam int TAIL_CYCLES = 2200;
  localparam int HOLD_CYCLES = 9000;
  localparam logic [ADDR_W-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

  class residue_scoreboard;
    logic [RES_W-1:0] pending[$];
    logic [RES_W-1:0] modulus_reg = MOD_RESET;
    int unsigned mismatches = 0;

    // right-to-left square-and-multiply, all products below 2^62
    function logic [RES_W-1:0] power_mod(logic [BASE_W-1:0] b, logic [31:0] e);
      logic [63:0] m, acc, sq;
      m = 64'(modulus_reg) & ((64'd1 << MOD_BITS_DEF) - 64'd1);
      if (m == 64'd0) return '0;
      acc = 64'd1 % m;
      sq  = 64'(b) % m;
      for (int i = 0; i < EXP_BITS_DEF && i < 32; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[RES_W-1:0];
    endfunction

    function void note_input(logic [BASE_W-1:0] b, logic [31:0] e);
      pending = {pending, power_mod(b, e)};
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_residue(logic [RES_W-1:0] got);
      logic [RES_W-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("residue %0d with no transaction pending", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("residue %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;
  logic              in_valid, in_ready;
  logic [BASE_W-1:0] base_value;
  logic [31:0]       exponent;
  logic              out_valid, out_ready;
  logic [RES_W-1:0]  residue;

  residue_scoreboard sb = new();
  int unsigned       cycles = 0;
  int unsigned       burst_left = 0;
  bit                hold_req = 1'b0;

  modular_exponentiation u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_value(base_value), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready), .residue(residue)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_residue(residue);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("[modular_exponentiation] ERROR");
      $finish;
    end
  end

  // offer one transaction; valid stays up across a burst, drops for the gap after it
  task automatic send_item(logic [BASE_W-1:0] b, logic [31:0] e);
    int unsigned gap;
    in_valid   <= 1'b1;
    base_value <= b;
    exponent   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, e);
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2200) : $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_modulus_readback();
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODULUS_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== DATA_W'(sb.modulus_reg))
      sb.report($sformatf("modulus reads %0d, want %0d", got, sb.modulus_reg));
  endtask

  task automatic set_modulus(logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODULUS_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.modulus_reg = v[RES_W-1:0];  // bit 31 is dropped
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    check_modulus_readback();
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    logic [BASE_W-1:0] b;
    case ($urandom_range(0, 5))
      0: b = $urandom_range(0, 3);
      1: b = 32'(sb.modulus_reg) + $urandom_range(0, 2) - 1;  // around the modulus
      2: b = 32'hFFFF_FFFF;
      default: b = $urandom;
    endcase
    return b;
  endfunction

  // mostly narrow exponents to keep the run short, a share at full width
  function automatic logic [31:0] pick_exponent();
    int unsigned w;
    logic [31:0] e;
    case ($urandom_range(0, 5))
      0: e = $urandom | 32'h8000_0000;
      1: e = $urandom_range(0, 3);
      default: begin
        w = $urandom_range(1, 32);
        e = $urandom;
        if (w < 32) e = e & ((32'd1 << w) - 32'd1);
      end
    endcase
    return e;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(pick_base(), pick_exponent());
  endtask

  initial begin : rx_ready
    int unsigned mode, mode_left, hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 3000);
        end else begin
          mode_left--;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    base_value = '0;
    exponent   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_modulus_readback();

    // reset modulus
    send_item(32'd0, 32'd0);  // zero exponent
    send_item(32'd0, 32'd1);
    send_item(32'd1, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd1000000007, 32'd5);  // base equals modulus
    send_item(32'd1000000008, 32'd77);
    send_item(32'd2, 32'd30);
    send_item(32'd3, 32'h8000_0000);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // modulus one: everything reduces to zero
    set_modulus(32'd1);
    send_item(32'd5, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // modulus zero: no reduction, residue zero
    set_modulus(32'd0);
    send_item(32'd5, 32'd7);
    send_item(32'd0, 32'd0);
    drain();

    set_modulus(32'h7FFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFE, 32'd2);
    send_item(32'h7FFF_FFFF, 32'd3);
    send_item(32'h8000_0000, 32'd2);
    run_random(60);
    drain();

    set_modulus(32'd2);
    run_random(30);
    drain();

    // register bit 31 must be ignored
    set_modulus($urandom | 32'h8000_0001);
    run_random(60);
    drain();

    // long receiver hold-off so the output and the datapath back up
    set_modulus($urandom_range(3, 1000));
    hold_req = 1'b1;
    run_random(70);
    drain();

    set_modulus($urandom_range(2, 32'h7FFF_FFFF));
    run_random(60);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

endmodule
